### hw/rtl/cpls_pkg.sv
// Shared constants and types for the convex polygon / line strip collision block.
package cpls_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = CoordW + DiffW;
  localparam int unsigned DotW   = ProdW + 1;
  localparam int unsigned PointW = 2 * CoordW;

  // Controller to datapath commands
  typedef struct packed {
    logic poly_wr;
    logic strip_wr;
    logic poly_clear;
    logic rd_axis;
    logic latch_axis;
    logic seg_axis;
    logic rd_seg;
    logic latch_seg;
    logic rd_vert;
    logic acc_vert;
    logic first_vert;
    logic decide;
    logic clear_run;
  } cpls_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_live;
    logic overflow;
  } cpls_sts_t;

endpackage

### hw/rtl/cpls_ram.sv
// Generic single write port RAM with registered read.
module cpls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/cpls_datapath.sv
// Datapath: point stores, axis, projections, interval compare, live bits.
module cpls_datapath import cpls_pkg::*; #(
  parameter int unsigned MaxPolyVerts   = 16,
  parameter int unsigned MaxStripPoints = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpls_cmd_t                     cmd_i,
  input  logic [PointW-1:0]             point_i,
  input  logic [$clog2(MaxPolyVerts)-1:0]   poly_addr_i,
  input  logic [$clog2(MaxStripPoints)-1:0] strip_addr_i,
  input  logic [$clog2(MaxStripPoints)-1:0] seg_i,
  input  logic                          ovf_set_i,
  output cpls_sts_t                     sts_o
);

  localparam int unsigned PA = $clog2(MaxPolyVerts);
  localparam int unsigned SA = $clog2(MaxStripPoints);

  logic [PointW-1:0] poly_rd, strip_rd;
  logic [PA-1:0]     poly_waddr;
  logic [SA-1:0]     strip_waddr;

  assign poly_waddr  = poly_addr_i;
  assign strip_waddr = strip_addr_i;

  cpls_ram #(.Width(PointW), .Depth(MaxPolyVerts)) u_poly (
    .clk_i, .we_i(cmd_i.poly_wr), .waddr_i(poly_waddr), .wdata_i(point_i),
    .raddr_i(poly_addr_i), .rdata_o(poly_rd)
  );
  cpls_ram #(.Width(PointW), .Depth(MaxStripPoints)) u_strip (
    .clk_i, .we_i(cmd_i.strip_wr), .waddr_i(strip_waddr), .wdata_i(point_i),
    .raddr_i(strip_addr_i), .rdata_o(strip_rd)
  );

  logic signed [CoordW-1:0] ax0_q, ay0_q, sx0_q, sy0_q;
  logic signed [DiffW-1:0]  axx_q, axy_q;
  logic signed [DotW-1:0]   pmin_q, pmax_q, d1_q;
  logic signed [DotW-1:0]   dot, lmin, lmax;
  logic                     have_first_q, have_d1_q;
  logic [MaxStripPoints-2:0] live_q;
  logic                     ovf_q;
  logic signed [CoordW-1:0] rx, ry;
  logic signed [ProdW-1:0]  mx_q, my_q;
  logic                     mvalid_q, mpoly_q;

  assign rx = poly_rd[CoordW-1:0];
  assign ry = poly_rd[PointW-1:CoordW];

  // Select the point fed into the projection multipliers
  logic signed [CoordW-1:0] qx, qy;
  assign qx = cmd_i.acc_vert ? rx : strip_rd[CoordW-1:0];
  assign qy = cmd_i.acc_vert ? ry : strip_rd[PointW-1:CoordW];

  assign dot = DotW'(mx_q) + DotW'(my_q);
  assign lmin = (d1_q < dot) ? d1_q : dot;
  assign lmax = (d1_q < dot) ? dot : d1_q;

  // Axis capture, multiply stage, accumulate, live update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '1;
      ovf_q        <= 1'b0;
      have_first_q <= 1'b0;
      have_d1_q    <= 1'b0;
      mvalid_q     <= 1'b0;
      mpoly_q      <= 1'b0;
    end else begin
      if (ovf_set_i) ovf_q <= 1'b1;
      if (cmd_i.clear_run) begin
        live_q <= '1;
        ovf_q  <= 1'b0;
      end
      if (cmd_i.rd_axis) begin
        ax0_q <= cmd_i.seg_axis ? strip_rd[CoordW-1:0] : rx;
        ay0_q <= cmd_i.seg_axis ? strip_rd[PointW-1:CoordW] : ry;
      end
      if (cmd_i.latch_axis) begin
        axx_q <= DiffW'(ay0_q)
               - DiffW'(cmd_i.seg_axis ? $signed(strip_rd[PointW-1:CoordW]) : ry);
        axy_q <= DiffW'(cmd_i.seg_axis ? $signed(strip_rd[CoordW-1:0]) : rx)
               - DiffW'(ax0_q);
      end
      mvalid_q <= cmd_i.acc_vert || cmd_i.rd_seg || cmd_i.latch_seg;
      mpoly_q  <= cmd_i.acc_vert;
      // Hold the products between projections
      if (cmd_i.acc_vert || cmd_i.rd_seg || cmd_i.latch_seg) begin
        mx_q <= ProdW'(qx) * ProdW'(axx_q);
        my_q <= ProdW'(qy) * ProdW'(axy_q);
      end
      if (cmd_i.first_vert) begin
        have_first_q <= 1'b0;
        have_d1_q    <= 1'b0;
      end else if (mvalid_q) begin
        if (mpoly_q) begin
          if (!have_first_q || dot < pmin_q) pmin_q <= dot;
          if (!have_first_q || dot > pmax_q) pmax_q <= dot;
          have_first_q <= 1'b1;
        end else if (!have_d1_q) begin
          d1_q      <= dot;
          have_d1_q <= 1'b1;
        end
      end
      if (cmd_i.decide) begin
        if (!(have_first_q && lmax >= pmin_q && pmax_q >= lmin)) begin
          live_q[seg_i[SA-1:0] < SA'(MaxStripPoints-1) ? seg_i : '0] <= 1'b0;
        end
      end
    end
  end

  logic [MaxStripPoints-2:0] mask;
  always_comb begin
    for (int k = 0; k < MaxStripPoints-1; k++) begin
      mask[k] = (SA+1)'(k) < (SA+1)'(strip_addr_i) + (SA+1)'(0) ? 1'b1 : 1'b0;
    end
  end

  assign sts_o.any_live = |(live_q & mask);
  assign sts_o.overflow = ovf_q;

endmodule

### hw/rtl/cpls_ctrl.sv
// Controller: load sequencing and the edge by segment test walk.
module cpls_ctrl import cpls_pkg::*; #(
  parameter int unsigned MaxPolyVerts   = 16,
  parameter int unsigned MaxStripPoints = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_mode_i,
  input  logic                   in_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_hit_o,
  output logic                   out_ovf_o,
  output cpls_cmd_t              cmd_o,
  output logic [$clog2(MaxPolyVerts)-1:0]   poly_addr_o,
  output logic [$clog2(MaxStripPoints)-1:0] strip_addr_o,
  output logic [$clog2(MaxStripPoints)-1:0] seg_o,
  output logic                   ovf_set_o,
  input  cpls_sts_t              sts_i
);

  localparam int unsigned PA = $clog2(MaxPolyVerts);
  localparam int unsigned SA = $clog2(MaxStripPoints);
  localparam int unsigned PC = $clog2(MaxPolyVerts + 1);
  localparam int unsigned SC = $clog2(MaxStripPoints + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StAxA   = 4'd1;
  localparam logic [3:0] StAxB   = 4'd2;
  localparam logic [3:0] StAxL   = 4'd3;
  localparam logic [3:0] StVert  = 4'd4;
  localparam logic [3:0] StSegA  = 4'd5;
  localparam logic [3:0] StSegB  = 4'd6;
  localparam logic [3:0] StWait1 = 4'd7;
  localparam logic [3:0] StWait2 = 4'd8;
  localparam logic [3:0] StDec   = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;
  localparam logic [3:0] StRes   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [PC-1:0] pcnt_q, pcnt_d;
  logic [SC-1:0] scnt_q, scnt_d;
  logic          closed_q, closed_d;
  logic          phase2_q, phase2_d;
  logic [PC-1:0] edge_q, edge_d, vcnt_q, vcnt_d;
  logic [SC-1:0] seg_q, seg_d;
  logic          hit_q, hit_d, ovf_q, ovf_d;
  logic [PC-1:0] pcnt_eff, nxt;
  logic [SC-1:0] nseg;
  logic          acc;

  assign in_ready_o  = (state_q == StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StRes);
  assign out_hit_o   = hit_q;
  assign out_ovf_o   = ovf_q;
  assign seg_o       = seg_q[SA-1:0];
  assign pcnt_eff    = (closed_q && !in_mode_i) ? '0 : pcnt_q;
  assign nseg        = (scnt_q >= SC'(2)) ? scnt_q - SC'(1) : '0;
  assign nxt         = (edge_q + PC'(1) == pcnt_q) ? '0 : edge_q + PC'(1);

  // Sequence loads and the test walk
  always_comb begin
    state_d = state_q; pcnt_d = pcnt_q; scnt_d = scnt_q; closed_d = closed_q;
    phase2_d = phase2_q; edge_d = edge_q; vcnt_d = vcnt_q; seg_d = seg_q;
    hit_d = hit_q; ovf_d = ovf_q;
    cmd_o = '0; ovf_set_o = 1'b0;
    poly_addr_o = '0; strip_addr_o = scnt_q[SA-1:0];
    case (state_q)
      StIdle: begin
        poly_addr_o = pcnt_eff[PA-1:0];
        if (acc) begin
          if (!in_mode_i) begin
            closed_d = in_last_i;
            if (pcnt_eff < PC'(MaxPolyVerts)) begin
              cmd_o.poly_wr = 1'b1;
              pcnt_d = pcnt_eff + PC'(1);
            end else begin
              pcnt_d = pcnt_eff;
              ovf_set_o = 1'b1;
            end
          end else begin
            if (scnt_q < SC'(MaxStripPoints)) begin
              cmd_o.strip_wr = 1'b1;
              scnt_d = scnt_q + SC'(1);
            end else begin
              ovf_set_o = 1'b1;
            end
            if (in_last_i) begin
              state_d = StAxA; phase2_d = 1'b0; edge_d = '0; seg_d = '0;
            end
          end
        end
      end
      StAxA: begin
        // Pick the axis: polygon edge or current segment
        if (pcnt_q == '0 || nseg == '0) begin
          state_d = StOut;
        end else if (!phase2_q && edge_q >= pcnt_q) begin
          phase2_d = 1'b1; seg_d = '0;
        end else if (phase2_q && seg_q >= nseg) begin
          state_d = StOut;
        end else begin
          poly_addr_o  = edge_q[PA-1:0];
          strip_addr_o = seg_q[SA-1:0];
          state_d = StAxB;
        end
      end
      StAxB: begin
        cmd_o.rd_axis = 1'b1; cmd_o.seg_axis = phase2_q;
        poly_addr_o  = nxt[PA-1:0];
        strip_addr_o = SA'(seg_q + SC'(1));
        state_d = StAxL;
      end
      StAxL: begin
        cmd_o.latch_axis = 1'b1; cmd_o.seg_axis = phase2_q;
        cmd_o.first_vert = 1'b1; vcnt_d = '0;
        poly_addr_o = '0;
        state_d = StVert;
      end
      StVert: begin
        // Stream polygon vertices through the projection
        poly_addr_o = PA'(vcnt_q);
        cmd_o.acc_vert = (vcnt_q != '0);
        vcnt_d = vcnt_q + PC'(1);
        if (vcnt_q == pcnt_q) begin
          strip_addr_o = seg_q[SA-1:0];
          state_d = StSegA;
        end
      end
      StSegA: begin
        strip_addr_o = SA'(seg_q + SC'(1));
        cmd_o.rd_seg = 1'b1;
        state_d = StSegB;
      end
      StSegB: begin
        cmd_o.latch_seg = 1'b1;
        state_d = StWait1;
      end
      StWait1: state_d = StWait2;
      StWait2: begin
        cmd_o.decide = 1'b1;
        state_d = StDec;
      end
      StDec: begin
        // Advance segment, then edge
        state_d = StAxA;
        if (phase2_q) begin
          seg_d = seg_q + SC'(1);
        end else if (seg_q + SC'(1) >= nseg) begin
          seg_d = '0; edge_d = edge_q + PC'(1);
        end else begin
          seg_d = seg_q + SC'(1);
        end
      end
      StOut: begin
        hit_d = (pcnt_q != '0) && sts_i.any_live;
        ovf_d = sts_i.overflow;
        strip_addr_o = nseg[SA-1:0] + SA'(nseg == SC'(MaxStripPoints) ? 0 : 0);
        state_d = StRes;
      end
      StRes: begin
        if (out_ready_i) begin
          cmd_o.clear_run = 1'b1;
          scnt_d = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; pcnt_q <= '0; scnt_q <= '0; closed_q <= 1'b0;
      phase2_q <= 1'b0; edge_q <= '0; vcnt_q <= '0; seg_q <= '0;
      hit_q <= 1'b0; ovf_q <= 1'b0;
    end else begin
      state_q <= state_d; pcnt_q <= pcnt_d; scnt_q <= scnt_d; closed_q <= closed_d;
      phase2_q <= phase2_d; edge_q <= edge_d; vcnt_q <= vcnt_d; seg_q <= seg_d;
      hit_q <= hit_d; ovf_q <= ovf_d;
    end
  end

endmodule

### hw/rtl/convex_polygon_line_strip_collision_top.sv
// Top level of the convex polygon versus line strip collision block.
// Points load one per cycle while the block is idle (ready stays high). The strip point
// flagged tlast starts a separating-axis walk run by one shared projection unit (two
// multipliers and an adder), with the input ready low until the result beat is taken:
// every edge axis is tried on every segment and each segment axis on its own segment, for
// V edge axes times S segments plus S segment axes, where V is the vertex count and S the
// segment count. One result beat (hit, overflow) follows; the polygon is kept for later
// strips.
module convex_polygon_line_strip_collision_top import cpls_pkg::*; #(
  parameter int unsigned MAX_POLY_VERTS   = 16,
  parameter int unsigned MAX_STRIP_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // coord_x[15:0], coord_y[31:16]
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // hit[0], overflow[1], zero fill
);

  cpls_cmd_t cmd;
  cpls_sts_t sts;
  logic [$clog2(MAX_POLY_VERTS)-1:0]   poly_addr;
  logic [$clog2(MAX_STRIP_POINTS)-1:0] strip_addr, seg;
  logic ovf_set, hit, ovf;

  cpls_ctrl #(.MaxPolyVerts(MAX_POLY_VERTS), .MaxStripPoints(MAX_STRIP_POINTS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_mode_i(s_axis_tuser), .in_last_i(s_axis_tlast),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_hit_o(hit), .out_ovf_o(ovf),
    .cmd_o(cmd), .poly_addr_o(poly_addr), .strip_addr_o(strip_addr), .seg_o(seg),
    .ovf_set_o(ovf_set), .sts_i(sts)
  );

  cpls_datapath #(.MaxPolyVerts(MAX_POLY_VERTS), .MaxStripPoints(MAX_STRIP_POINTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .point_i(s_axis_tdata),
    .poly_addr_i(poly_addr), .strip_addr_i(strip_addr), .seg_i(seg),
    .ovf_set_i(ovf_set), .sts_o(sts)
  );

  assign m_axis_tdata = {6'b0, ovf, hit};

endmodule

### test/convex_polygon_line_strip_collision_checker.sv
// Checker for the polygon / line strip collision block: predicts each result beat and compares.
module convex_polygon_line_strip_collision_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // coord_x[15:0], coord_y[31:16]
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,  // last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // hit[0], overflow[1], zero fill
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PolyDepth  = 16;
  localparam int unsigned StripDepth = 16;

  typedef struct packed {
    logic hit;
    logic overflow;
  } verdict_t;

  logic signed [15:0] poly_x [PolyDepth];
  logic signed [15:0] poly_y [PolyDepth];
  logic signed [15:0] strip_x [StripDepth];
  logic signed [15:0] strip_y [StripDepth];
  int unsigned        poly_cnt;
  int unsigned        strip_cnt;
  bit                 dropped;
  bit                 poly_closed;
  verdict_t           verdict_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = verdict_q.size();

  // True if segment s..s+1 and the polygon overlap when projected on (ax, ay)
  function automatic bit seg_overlaps(int unsigned s, longint ax, longint ay);
    longint pmin, pmax, d, d1, d2, lmin, lmax;
    pmin = 0;
    pmax = 0;
    if (poly_cnt == 0) return 1'b0;
    for (int unsigned k = 0; k < poly_cnt; k++) begin
      d = longint'(poly_x[k]) * ax + longint'(poly_y[k]) * ay;
      if (k == 0 || d < pmin) pmin = d;
      if (k == 0 || d > pmax) pmax = d;
    end
    d1 = longint'(strip_x[s]) * ax + longint'(strip_y[s]) * ay;
    d2 = longint'(strip_x[s+1]) * ax + longint'(strip_y[s+1]) * ay;
    lmin = (d1 < d2) ? d1 : d2;
    lmax = (d1 < d2) ? d2 : d1;
    return (lmax >= pmin) && (pmax >= lmin);
  endfunction

  // Walk edge axes, then segment axes; report whether any segment survives
  function automatic bit strip_hits_polygon();
    bit          live [StripDepth];
    int unsigned nseg;
    int unsigned j;
    longint      ax, ay;
    bit          any;
    nseg = (strip_cnt >= 2) ? strip_cnt - 1 : 0;
    any  = 1'b0;
    foreach (live[s]) live[s] = 1'b1;
    for (int unsigned i = 0; i < poly_cnt; i++) begin
      j  = (i + 1 == poly_cnt) ? 0 : i + 1;
      ax = -(longint'(poly_y[j]) - longint'(poly_y[i]));
      ay = longint'(poly_x[j]) - longint'(poly_x[i]);
      for (int unsigned s = 0; s < nseg; s++)
        if (live[s] && !seg_overlaps(s, ax, ay)) live[s] = 1'b0;
    end
    for (int unsigned s = 0; s < nseg; s++) begin
      if (live[s]) begin
        ax = -(longint'(strip_y[s+1]) - longint'(strip_y[s]));
        ay = longint'(strip_x[s+1]) - longint'(strip_x[s]);
        if (!seg_overlaps(s, ax, ay)) live[s] = 1'b0;
      end
    end
    for (int unsigned s = 0; s < nseg; s++) if (live[s]) any = 1'b1;
    return any;
  endfunction

  // Compare result beats first, then absorb the input beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      poly_cnt    <= 0;
      strip_cnt   <= 0;
      dropped     <= 1'b0;
      poly_closed <= 1'b0;
      fails       <= 0;
      verdict_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          fails = fails + 1;
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_axis_tdata[0] !== exp_v.hit) begin
            $error("hit: expected %0b, actual %0b", exp_v.hit, m_axis_tdata[0]);
            fails = fails + 1;
          end
          if (m_axis_tdata[1] !== exp_v.overflow) begin
            $error("overflow: expected %0b, actual %0b", exp_v.overflow, m_axis_tdata[1]);
            fails = fails + 1;
          end
          if (m_axis_tdata[7:2] !== 6'd0) begin
            $error("fill: expected 0, actual %0h", m_axis_tdata[7:2]);
            fails = fails + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!s_axis_tuser) begin
          // Polygon vertex: a vertex after a closed polygon starts a new one
          if (poly_closed) begin
            poly_cnt    = 0;
            poly_closed = 1'b0;
          end
          if (poly_cnt < PolyDepth) begin
            poly_x[poly_cnt] = s_axis_tdata[15:0];
            poly_y[poly_cnt] = s_axis_tdata[31:16];
            poly_cnt         = poly_cnt + 1;
          end else begin
            dropped = 1'b1;
          end
          if (s_axis_tlast) poly_closed = 1'b1;
        end else begin
          // Strip point: the last one runs the test
          if (strip_cnt < StripDepth) begin
            strip_x[strip_cnt] = s_axis_tdata[15:0];
            strip_y[strip_cnt] = s_axis_tdata[31:16];
            strip_cnt          = strip_cnt + 1;
          end else begin
            dropped = 1'b1;
          end
          if (s_axis_tlast) begin
            exp_v.hit      = strip_hits_polygon();
            exp_v.overflow = dropped;
            verdict_q.push_back(exp_v);
            strip_cnt = 0;
            dropped   = 1'b0;
          end
        end
      end
    end
  end

endmodule

### test/convex_polygon_line_strip_collision_top_test.sv
// Stimulus and verdict for the polygon / line strip collision block.
module convex_polygon_line_strip_collision_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 900;
  localparam int CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // coord_x[15:0], coord_y[31:16]
  logic        s_axis_tuser;   // mode
  logic        s_axis_tlast;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // hit[0], overflow[1], zero fill
  int          fail_count;
  int          pending;
  int          items_sent;
  int          cycles;
  int          ready_cycles;

  // Unit directions scaled by 100, eight around the circle
  int dir_x [8] = '{100, 71, 0, -71, -100, -71, 0, 71};
  int dir_y [8] = '{0, 71, 100, 71, 0, -71, -100, -71};

  convex_polygon_line_strip_collision_top uut (.*);

  convex_polygon_line_strip_collision_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("convex_polygon_line_strip_collision_top_test NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, one stretch always ready
  always @(posedge clk_i) begin
    ready_cycles <= ready_cycles + 1;
    if (ready_cycles >= 20000 && ready_cycles < 23000) begin
      m_axis_tready <= 1'b0;
    end else if (ready_cycles >= 40000 && ready_cycles < 70000) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 8);
    end
  end

  // Offer one beat, with random gaps before it outside the no-idle stretch
  task automatic send_point(bit mode, logic [15:0] x, logic [15:0] y, bit tl);
    bit quiet;
    quiet = (items_sent >= 400 && items_sent < 550);
    while (!quiet && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= tl;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Convex polygon of n vertices (n in 3..8) around (cx, cy)
  task automatic send_polygon(int n, int cx, int cy, int r);
    int k;
    for (int i = 0; i < n; i++) begin
      k = (i * 8) / n;
      send_point(1'b0, 16'(cx + dir_x[k] * r / 100), 16'(cy + dir_y[k] * r / 100), i == n - 1);
    end
  endtask

  // Strip of n points scattered around (cx, cy)
  task automatic send_strip(int n, int cx, int cy, int r);
    int dx, dy;
    for (int i = 0; i < n; i++) begin
      dx = $urandom_range(2 * r) - r;
      dy = $urandom_range(2 * r) - r;
      send_point(1'b1, 16'(cx + dx), 16'(cy + dy), i == n - 1);
    end
  endtask

  initial begin
    int cx, cy, r, n, pick;
    cycles        = 0;
    ready_cycles  = 0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: strip with no polygon yet
    send_point(1'b1, 16'h0000, 16'h0000, 1'b0);
    send_point(1'b1, 16'h0100, 16'h0100, 1'b1);
    // Unclosed single vertex, then a one-point strip
    send_point(1'b0, 16'h0000, 16'h0000, 1'b0);
    send_point(1'b1, 16'h0000, 16'h0000, 1'b1);
    // Two-vertex polygon at the extremes, strip across it with a zero-length segment
    send_point(1'b0, 16'h8000, 16'h8000, 1'b0);
    send_point(1'b0, 16'h7fff, 16'h7fff, 1'b1);
    send_point(1'b1, 16'h8000, 16'h7fff, 1'b0);
    send_point(1'b1, 16'h8000, 16'h7fff, 1'b0);
    send_point(1'b1, 16'h7fff, 16'h8000, 1'b1);
    // Extreme square, strip outside and then through it
    send_polygon(4, 0, 0, 32000);
    send_point(1'b1, 16'h7fff, 16'h7fff, 1'b0);
    send_point(1'b1, 16'h7fff, 16'h7000, 1'b1);
    send_point(1'b1, 16'h8000, 16'h0000, 1'b0);
    send_point(1'b1, 16'h7fff, 16'h0000, 1'b1);

    // Random: mostly well-formed polygons and strips near each other, some noise
    cx = 0;
    cy = 0;
    r  = 500;
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        cx = $urandom_range(40000) - 20000;
        cy = $urandom_range(40000) - 20000;
        r  = $urandom_range(2000, 10);
        send_polygon($urandom_range(8, 3), cx, cy, r);
      end else if (pick < 24) begin
        // Oversized polygon: later vertices are dropped
        n = $urandom_range(19, 17);
        for (int i = 0; i < n; i++)
          send_point(1'b0, 16'($urandom), 16'($urandom), i == n - 1);
      end else if (pick < 28) begin
        // Oversized strip, dropped last point still ends it
        send_strip($urandom_range(18, 17), cx, cy, 3 * r);
      end else if (pick < 36) begin
        // Noise: full-range points of either kind
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
          send_point($urandom_range(1), 16'($urandom), 16'($urandom), i == n - 1);
      end else begin
        send_strip($urandom_range(5, 1), cx, cy, 3 * r);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("convex_polygon_line_strip_collision_top_test OK");
    end else begin
      $display("convex_polygon_line_strip_collision_top_test NOT OK");
    end
    $finish;
  end

endmodule
